// File: rtl/first_fit_buffer_pool_unit_assert.svh
// Assertion macros for the first-fit buffer pool unit.
// Needs clk and rst_n in the scope of the file that uses them.
`ifndef FIRST_FIT_BUFFER_POOL_UNIT_ASSERT_SVH
`define FIRST_FIT_BUFFER_POOL_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define FFBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FFBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FFBP_ASSERT_NOW(lbl, ante, cons, msg)
`define FFBP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/ffbp_pkg.sv
// Shared constants and types of the first-fit buffer pool unit.
// No dependencies.
package ffbp_pkg;

    localparam int POOL_ENTRIES = 16;
    localparam int IDX_W = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

    localparam logic [31:0] BUDGET_RESET = 32'd67108864;

    typedef logic [1:0] op_t;
    typedef logic [2:0] status_t;

    localparam op_t OP_ALLOC   = 2'd0;
    localparam op_t OP_RELEASE = 2'd1;
    localparam op_t OP_CLEAR   = 2'd2;

    localparam status_t ST_REUSED    = 3'd0;
    localparam status_t ST_NEW       = 3'd1;
    localparam status_t ST_ZERO      = 3'd2;
    localparam status_t ST_BUDGET    = 3'd3;
    localparam status_t ST_FULL      = 3'd4;
    localparam status_t ST_RELEASED  = 3'd5;
    localparam status_t ST_NOT_FOUND = 3'd6;
    localparam status_t ST_CLEARED   = 3'd7;

endpackage

// File: rtl/first_fit_buffer_pool_unit.sv
// First-fit buffer pool allocator with a byte budget: top level.
// Depends on ffbp_pkg and first_fit_buffer_pool_unit_assert.svh.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  request   | start / busy         | operation, request_bytes, release_index
//  result    | done (1-cycle strobe)| status, entry_index, entry_bytes, total_bytes
//  config    | cfg_we               | cfg_wdata (budget in bytes)
//
// Release, clear, zero-size and unused operations are decided in the idle state: the
// result beat shows on the cycle after start. An allocate walks the size/busy
// memories one entry per cycle (registered read, next read issued while
// the current entry is checked) and stops at the first free entry that fits;
// if none fits, or the pool is empty, a decide state does the budget add/compare,
// the full check and the append. busy is high while an allocate is in flight.
// Reset clears the entry count, the byte total and the budget (to 64 MiB);
// the memories need no clearing since only entries below the count are read.
// The receiver cannot stall: each result beat is valid for one cycle only.
`include "first_fit_buffer_pool_unit_assert.svh"

module first_fit_buffer_pool_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ffbp_pkg::op_t     operation,
    input  logic [31:0]       request_bytes,
    input  logic [7:0]        release_index,
    input  logic              cfg_we,
    input  logic [31:0]       cfg_wdata,
    output logic              done,
    output ffbp_pkg::status_t status,
    output logic [7:0]        entry_index,
    output logic [31:0]       entry_bytes,
    output logic [31:0]       total_bytes
);
    import ffbp_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    // control state
    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      total_reg, total_next;
    logic [31:0]      budget_reg;
    logic [IDX_W-1:0] chk_reg, chk_next;
    logic             done_reg, done_next;

    // request and result payload
    logic [31:0]      req_reg, req_next;
    status_t          status_reg, status_next;
    logic [7:0]       eidx_reg, eidx_next;
    logic [31:0]      ebytes_reg, ebytes_next;

    // entry memories: size and busy mark
    logic [31:0]      size_mem [POOL_ENTRIES];
    logic             busy_mem [POOL_ENTRIES];
    logic [IDX_W-1:0] rd_addr;
    logic [31:0]      rd_size_reg;
    logic             rd_busy_reg;
    logic             size_we;
    logic             busy_we;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_busy;

    logic [32:0]      sum;
    logic             hit;
    logic             last_chk;

    assign sum      = {1'b0, total_reg} + {1'b0, req_reg};
    assign hit      = !rd_busy_reg && (rd_size_reg >= req_reg);
    assign last_chk = (CNT_W'(chk_reg) + CNT_W'(1)) == count_reg;

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        total_next  = total_reg;
        chk_next    = chk_reg;
        done_next   = 1'b0;
        req_next    = req_reg;
        status_next = status_reg;
        eidx_next   = eidx_reg;
        ebytes_next = ebytes_reg;
        rd_addr     = '0;
        size_we     = 1'b0;
        busy_we     = 1'b0;
        wr_addr     = '0;
        wr_busy     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next    = request_bytes;
                    eidx_next   = '0;
                    ebytes_next = '0;
                    unique case (operation)
                        OP_ALLOC:
                        begin
                            if (request_bytes == '0)
                            begin
                                status_next = ST_ZERO;
                                done_next   = 1'b1;
                            end
                            else if (count_reg == '0)
                            begin
                                state_next = S_DECIDE;
                            end
                            else
                            begin
                                chk_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        OP_RELEASE:
                        begin
                            done_next = 1'b1;
                            if (9'(release_index) < 9'(count_reg))
                            begin
                                busy_we     = 1'b1;
                                wr_addr     = release_index[IDX_W-1:0];
                                wr_busy     = 1'b0;
                                status_next = ST_RELEASED;
                                eidx_next   = release_index;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next  = '0;
                            total_next  = '0;
                            status_next = ST_CLEARED;
                            done_next   = 1'b1;
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // data for chk_reg is on the read port; fetch the next entry
                rd_addr = chk_reg + IDX_W'(1);
                if (hit)
                begin
                    busy_we     = 1'b1;
                    wr_addr     = chk_reg;
                    wr_busy     = 1'b1;
                    status_next = ST_REUSED;
                    eidx_next   = 8'(chk_reg);
                    ebytes_next = rd_size_reg;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (last_chk)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    chk_next = chk_reg + IDX_W'(1);
                end
            end
            S_DECIDE:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (sum > {1'b0, budget_reg})
                begin
                    status_next = ST_BUDGET;
                end
                else if (count_reg == CNT_W'(POOL_ENTRIES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    size_we     = 1'b1;
                    busy_we     = 1'b1;
                    wr_addr     = count_reg[IDX_W-1:0];
                    wr_busy     = 1'b1;
                    count_next  = count_reg + CNT_W'(1);
                    total_next  = sum[31:0];
                    status_next = ST_NEW;
                    eidx_next   = 8'(count_reg);
                    ebytes_next = req_reg;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            total_reg  <= '0;
            budget_reg <= BUDGET_RESET;
            chk_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
            chk_reg   <= chk_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                budget_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        eidx_reg   <= eidx_next;
        ebytes_reg <= ebytes_next;
    end

    // entry memories, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (size_we)
        begin
            size_mem[wr_addr] <= req_reg;
        end
        if (busy_we)
        begin
            busy_mem[wr_addr] <= wr_busy;
        end
        rd_size_reg <= size_mem[rd_addr];
        rd_busy_reg <= busy_mem[rd_addr];
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_index = eidx_reg;
    assign entry_bytes = ebytes_reg;
    assign total_bytes = total_reg;

    `FFBP_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(POOL_ENTRIES), "count overflow")
    `FFBP_ASSERT_NOW(a_scan_nonempty, state_reg == S_SCAN, count_reg != '0, "scan of empty pool")
    `FFBP_ASSERT_NOW(a_done_idle, done_reg, state_reg == S_IDLE, "result beat while busy")
    `FFBP_ASSERT_NXT(a_accept_moves, start && !busy, busy || done, "accepted beat lost")

endmodule

// File: bench/first_fit_buffer_pool_unit_tb.sv
// Self-checking bench for first_fit_buffer_pool_unit: a directed table, then random
// phases under several budgets, all checked beat by beat against a local pool model.
// Needs ffbp_pkg and the unit's RTL; reads no files.
`timescale 1ns / 100ps

module first_fit_buffer_pool_unit_tb;
    import ffbp_pkg::*;

    // operation code 3 has no meaning in the unit; it must answer not found
    localparam op_t OP_UNUSED = 2'd3;

    typedef struct packed {
        status_t     status;
        logic [7:0]  entry_index;
        logic [31:0] entry_bytes;
        logic [31:0] total_bytes;
    } pool_reply_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] request_bytes;
        logic [7:0]  release_index;
        logic        typed;      // reply below is known by inspection
        pool_reply_t reply;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    op_t         operation;
    logic [31:0] request_bytes;
    logic [7:0]  release_index;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        done;
    status_t     status;
    logic [7:0]  entry_index;
    logic [31:0] entry_bytes;
    logic [31:0] total_bytes;

    // shadow of the pool, kept in step with every accepted beat
    logic [31:0] pm_size [POOL_ENTRIES];
    bit          pm_busy [POOL_ENTRIES];
    int          pm_count;
    logic [31:0] pm_total;
    logic [31:0] pm_budget;

    pool_reply_t expected_replies[$];
    int          error_count;
    bit          gapless;

    // Directed table. After reset the budget is 64 MiB; the second append fills
    // it exactly, so a one-byte append right after must be refused.
    plan_row_t directed_plan [19] = '{
        '{OP_RELEASE, 32'd0,        8'd0,   1'b1, '{ST_NOT_FOUND, 8'd0, 32'd0, 32'd0}},
        '{OP_ALLOC,   32'd0,        8'hFF,  1'b1, '{ST_ZERO,      8'd0, 32'd0, 32'd0}},
        '{OP_UNUSED,  32'hFFFFFFFF, 8'hFF,  1'b1, '{ST_NOT_FOUND, 8'd0, 32'd0, 32'd0}},
        '{OP_ALLOC,   32'd100,      8'd0,   1'b1, '{ST_NEW,       8'd0, 32'd100, 32'd100}},
        '{OP_ALLOC,   32'hFFFFFFFF, 8'd0,   1'b1, '{ST_BUDGET,    8'd0, 32'd0, 32'd100}},
        '{OP_ALLOC,   32'd67108764, 8'd0,   1'b1,
            '{ST_NEW, 8'd1, 32'd67108764, 32'd67108864}},
        '{OP_ALLOC,   32'd1,        8'd0,   1'b1, '{ST_BUDGET,    8'd0, 32'd0, 32'd67108864}},
        '{OP_RELEASE, 32'd0,        8'd0,   1'b1, '{ST_RELEASED,  8'd0, 32'd0, 32'd67108864}},
        // releasing an already free entry still reports released
        '{OP_RELEASE, 32'd0,        8'd0,   1'b1, '{ST_RELEASED,  8'd0, 32'd0, 32'd67108864}},
        // exact fit reuses entry 0
        '{OP_ALLOC,   32'd100,      8'd0,   1'b1, '{ST_REUSED, 8'd0, 32'd100, 32'd67108864}},
        '{OP_RELEASE, 32'd0,        8'd1,   1'b1, '{ST_RELEASED,  8'd1, 32'd0, 32'd67108864}},
        '{OP_ALLOC,   32'd101,      8'd0,   1'b0, '0},
        '{OP_ALLOC,   32'd1,        8'd0,   1'b0, '0},
        // index equal to the entry count is just out of range
        '{OP_RELEASE, 32'd0,        8'd2,   1'b1, '{ST_NOT_FOUND, 8'd0, 32'd0, 32'd67108864}},
        '{OP_RELEASE, 32'd0,        8'hFF,  1'b1, '{ST_NOT_FOUND, 8'd0, 32'd0, 32'd67108864}},
        '{OP_RELEASE, 32'd0,        8'h80,  1'b0, '0},
        '{OP_CLEAR,   32'd0,        8'd0,   1'b1, '{ST_CLEARED,   8'd0, 32'd0, 32'd0}},
        '{OP_CLEAR,   32'd0,        8'd0,   1'b1, '{ST_CLEARED,   8'd0, 32'd0, 32'd0}},
        '{OP_ALLOC,   32'd1,        8'd0,   1'b0, '0}
    };

    first_fit_buffer_pool_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .request_bytes (request_bytes),
        .release_index (release_index),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .done          (done),
        .status        (status),
        .entry_index   (entry_index),
        .entry_bytes   (entry_bytes),
        .total_bytes   (total_bytes)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Pool model: first free entry that fits, else append within budget and slots.
    function automatic pool_reply_t pool_predict(op_t op, logic [31:0] req, logic [7:0] idx);
        pool_reply_t r;
        logic [32:0] sum;
        bit          placed;
        r = '0;
        r.status = ST_NOT_FOUND;
        placed = 1'b0;
        case (op)
            OP_ALLOC:
            begin
                if (req == 32'd0)
                    r.status = ST_ZERO;
                else
                begin
                    for (int i = 0; i < pm_count; i++)
                    begin
                        if (!placed && !pm_busy[i] && pm_size[i] >= req)
                        begin
                            placed = 1'b1;
                            pm_busy[i] = 1'b1;
                            r.status = ST_REUSED;
                            r.entry_index = 8'(i);
                            r.entry_bytes = pm_size[i];
                        end
                    end
                    if (!placed)
                    begin
                        // budget test is done at 33 bits, so no wrap
                        sum = {1'b0, pm_total} + {1'b0, req};
                        if (sum > {1'b0, pm_budget})
                            r.status = ST_BUDGET;
                        else if (pm_count >= POOL_ENTRIES)
                            r.status = ST_FULL;
                        else
                        begin
                            pm_size[pm_count] = req;
                            pm_busy[pm_count] = 1'b1;
                            r.status = ST_NEW;
                            r.entry_index = 8'(pm_count);
                            r.entry_bytes = req;
                            pm_count++;
                            pm_total = sum[31:0];
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                if (int'(idx) < pm_count)
                begin
                    pm_busy[idx] = 1'b0;
                    r.status = ST_RELEASED;
                    r.entry_index = idx;
                end
            end
            OP_CLEAR:
            begin
                pm_count = 0;
                pm_total = 32'd0;
                r.status = ST_CLEARED;
            end
            default:
                r.status = ST_NOT_FOUND;
        endcase
        r.total_bytes = pm_total;
        return r;
    endfunction

    // Sizes: mostly scaled to the budget so the pool fills, plus zero, full-range
    // values and sizes within one byte of an existing entry to hit the fit boundary.
    function automatic logic [31:0] pick_request();
        logic [31:0] scale;
        logic [31:0] req;
        int          k;
        scale = (pm_budget >> 4) + 32'd1;
        k = $urandom_range(0, 9);
        req = $urandom_range(1, scale);
        if (k == 0)
            req = 32'd0;
        else if (k == 1)
            req = $urandom;
        else if (k <= 3 && pm_count > 0)
            req = pm_size[$urandom_range(0, pm_count - 1)] + $urandom_range(0, 2) - 32'd1;
        return req;
    endfunction

    function automatic logic [7:0] pick_index();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && pm_count > 0)
            return 8'($urandom_range(0, pm_count - 1));
        else if (k < 8)
            return 8'(pm_count);
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic op_t pick_op();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55)
            return OP_ALLOC;
        else if (k < 90)
            return OP_RELEASE;
        else if (k < 97)
            return OP_CLEAR;
        return OP_UNUSED;
    endfunction

    function automatic logic [31:0] phase_budget(int p);
        case (p)
            0, 9:    return 32'hFFFFFFFF;
            1:       return 32'd0;
            2:       return 32'd1000;
            4:       return pm_total >> 1;   // below what the pool already holds
            5:       return 32'h80000000;
            6:       return 32'd65536;
            7:       return BUDGET_RESET;
            8:       return 32'($urandom_range(1, 255));
            default: return $urandom;
        endcase
    endfunction

    // One command beat: optional idle gap, then hold start until busy is low at an edge.
    task automatic issue_beat(input op_t op, input logic [31:0] req, input logic [7:0] idx,
                              input logic typed, input pool_reply_t typed_reply);
        int          gap;
        pool_reply_t r;
        gap = gapless ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        operation <= op;
        request_bytes <= req;
        release_index <= idx;
        do
            @(posedge clk);
        while (busy);
        r = pool_predict(op, req, idx);
        expected_replies.insert(expected_replies.size(), typed ? typed_reply : r);
    endtask

    task automatic drain_replies();
        start <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // only called with the unit idle
    task automatic write_budget(input logic [31:0] value);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        pm_budget = value;
    endtask

    // Result beats last one cycle; sample them at the edge that ends it.
    always @(posedge clk)
    begin
        pool_reply_t exp_r;
        if (rst_n && done)
        begin
            if (expected_replies.size() == 0)
            begin
                $error("result beat with nothing expected: status %0d", status);
                error_count++;
            end
            else
            begin
                exp_r = expected_replies.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d, got %0d", exp_r.status, status);
                    error_count++;
                end
                if (entry_index !== exp_r.entry_index)
                begin
                    $error("entry_index: expected %0d, got %0d", exp_r.entry_index, entry_index);
                    error_count++;
                end
                if (entry_bytes !== exp_r.entry_bytes)
                begin
                    $error("entry_bytes: expected %0d, got %0d", exp_r.entry_bytes, entry_bytes);
                    error_count++;
                end
                if (total_bytes !== exp_r.total_bytes)
                begin
                    $error("total_bytes: expected %0d, got %0d", exp_r.total_bytes, total_bytes);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int fill;
        rst_n = 1'b0;
        start = 1'b0;
        operation = OP_ALLOC;
        request_bytes = 32'd0;
        release_index = 8'd0;
        cfg_we = 1'b0;
        cfg_wdata = 32'd0;
        error_count = 0;
        gapless = 1'b0;
        pm_count = 0;
        pm_total = 32'd0;
        pm_budget = BUDGET_RESET;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int n = 0; n < $size(directed_plan); n++)
            issue_beat(directed_plan[n].op, directed_plan[n].request_bytes,
                       directed_plan[n].release_index, directed_plan[n].typed,
                       directed_plan[n].reply);

        // Random phases, one budget each. Most open with a clear and a run of
        // appends that can fill the pool; phase 4 keeps the old contents so
        // the new budget lands below the current total.
        for (int p = 0; p < 10; p++)
        begin
            drain_replies();
            write_budget(phase_budget(p));
            gapless = (p % 3 == 1);
            if (p != 4)
            begin
                issue_beat(OP_CLEAR, $urandom, 8'($urandom_range(0, 255)), 1'b0, '0);
                fill = $urandom_range(10, 20);
                repeat (fill)
                    issue_beat(OP_ALLOC, $urandom_range(1, (pm_budget >> 4) + 32'd1),
                               8'($urandom_range(0, 255)), 1'b0, '0);
            end
            repeat (110)
                issue_beat(pick_op(), pick_request(), pick_index(), 1'b0, '0);
        end

        drain_replies();
        // room for a late or extra beat to show up
        repeat (40) @(posedge clk);
        if (error_count == 0 && expected_replies.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // watchdog: the full run needs well under a tenth of this
    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
